### rtl/cbm_pkg.sv
package cbm_pkg;

    localparam int PRG_BANK_BYTES = 16384;
    localparam int PATTERN_BYTES  = 8192;
    localparam int NAME_RAM_BYTES = 2048;
    localparam int PALETTE_BYTES  = 32;
    localparam int PRG_TOTAL      = 2 * PRG_BANK_BYTES;

    localparam int PRG_AW = $clog2(PRG_TOTAL);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAME_RAM_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    // Video space is 14 bits; the palette occupies 0x3F00-0x3FFF.
    localparam logic [5:0] PAL_PAGE = 6'h3F;

    typedef enum logic [1:0] {
        FUNC_CPU_READ   = 2'd0,
        FUNC_VIDEO_READ = 2'd1,
        FUNC_VIDEO_WRITE = 2'd2,
        FUNC_PRG_LOAD   = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTICAL_MIRRORING = 1'd0,
        CFG_TWO_PRG_BANKS      = 1'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_PRG  = 3'd1,
        SRC_PAT  = 3'd2,
        SRC_NT   = 3'd3,
        SRC_PAL  = 3'd4
    } t_src;

    // Name-table index: bit 10 comes from the quadrant column (vertical
    // mirroring) or the quadrant row (horizontal mirroring).
    function automatic logic [NT_AW-1:0] nt_index(input logic [ADDR_W-1:0] addr,
                                                  input logic vmirror);
        logic upper;
        begin
            upper = vmirror ? addr[10] : addr[11];
            nt_index = {upper, addr[9:0]};
        end
    endfunction

    // Entries 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C.
    function automatic logic [PAL_AW-1:0] pal_index(input logic [ADDR_W-1:0] addr);
        logic [PAL_AW-1:0] idx;
        begin
            idx = addr[PAL_AW-1:0];
            if (idx[1:0] == 2'b00) begin
                idx[PAL_AW-1] = 1'b0;
            end
            pal_index = idx;
        end
    endfunction

    function automatic logic [PRG_AW-1:0] prg_read_index(input logic [ADDR_W-1:0] addr,
                                                         input logic two_banks);
        begin
            prg_read_index = {two_banks & addr[14], addr[13:0]};
        end
    endfunction

endpackage

### rtl/cartridge_bus_mapper.sv
// Cartridge bus decoder for a fixed, unbanked cartridge. One access is taken
// in every clock cycle: busy is always low, so start alone issues an access.
// CPU reads and video reads return their byte on o_read_data with
// o_read_valid high for exactly one cycle, in the cycle after the access is
// taken; that delay is the registered read port of the single-ported
// memories. The receiver cannot stall, so it must capture the byte in that
// cycle. Video writes and program-ROM loads return nothing. A CPU read below
// 0x8000 returns zero. No memory is cleared at reset: program ROM, pattern
// store, name-table RAM and palette must be written before they are read. The
// user must write configuration via i_cfg_we with no read in flight (unenforced).
module cartridge_bus_mapper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_func,
    input  logic [cbm_pkg::ADDR_W-1:0]      i_bus_address,
    input  logic [cbm_pkg::DATA_W-1:0]      i_write_data,
    output logic                            o_read_valid,
    output logic [cbm_pkg::DATA_W-1:0]      o_read_data,
    input  logic                            i_cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [cbm_pkg::DATA_W-1:0] prg_mem [cbm_pkg::PRG_TOTAL];
    logic [cbm_pkg::DATA_W-1:0] pat_mem [cbm_pkg::PATTERN_BYTES];
    logic [cbm_pkg::DATA_W-1:0] nt_mem  [cbm_pkg::NAME_RAM_BYTES];
    logic [cbm_pkg::DATA_W-1:0] pal_mem [cbm_pkg::PALETTE_BYTES];

    logic [cbm_pkg::DATA_W-1:0] r_prg_rdata;
    logic [cbm_pkg::DATA_W-1:0] r_pat_rdata;
    logic [cbm_pkg::DATA_W-1:0] r_nt_rdata;
    logic [cbm_pkg::DATA_W-1:0] r_pal_rdata;

    logic r_vertical_mirroring;
    logic r_two_prg_banks;
    logic r_rd_valid;
    logic n_rd_valid;
    cbm_pkg::t_src r_src;
    cbm_pkg::t_src n_src;

    logic accept;
    cbm_pkg::t_func func;
    logic [cbm_pkg::ADDR_W-1:0] vaddr;

    logic prg_re, prg_we, pat_re, pat_we, nt_re, nt_we, pal_re, pal_we;
    logic [cbm_pkg::PRG_AW-1:0] prg_addr;
    logic [cbm_pkg::PAT_AW-1:0] pat_addr;
    logic [cbm_pkg::NT_AW-1:0]  nt_addr;
    logic [cbm_pkg::PAL_AW-1:0] pal_addr;

    // Every access completes its memory operation in the cycle it is taken.
    assign busy   = 1'b0;
    assign accept = start & ~busy;
    assign func   = cbm_pkg::t_func'(i_func);
    assign vaddr  = {2'b00, i_bus_address[13:0]};

    assign pat_addr = vaddr[cbm_pkg::PAT_AW-1:0];
    assign nt_addr  = cbm_pkg::nt_index(vaddr, r_vertical_mirroring);
    assign pal_addr = cbm_pkg::pal_index(vaddr);

    always_comb begin
        logic is_pat;
        logic is_pal;
        logic video_rd;
        logic video_wr;
        is_pat   = (vaddr[13] == 1'b0);
        is_pal   = (vaddr[13:8] == cbm_pkg::PAL_PAGE);
        video_rd = accept && (func == cbm_pkg::FUNC_VIDEO_READ);
        video_wr = accept && (func == cbm_pkg::FUNC_VIDEO_WRITE);

        prg_re = accept && (func == cbm_pkg::FUNC_CPU_READ) && i_bus_address[15];
        prg_we = accept && (func == cbm_pkg::FUNC_PRG_LOAD);
        prg_addr = prg_we ? i_bus_address[cbm_pkg::PRG_AW-1:0]
                          : cbm_pkg::prg_read_index(i_bus_address, r_two_prg_banks);

        pat_re = video_rd && is_pat;
        pat_we = video_wr && is_pat;
        pal_re = video_rd && is_pal;
        pal_we = video_wr && is_pal;
        nt_re  = video_rd && !is_pat && !is_pal;
        nt_we  = video_wr && !is_pat && !is_pal;

        n_rd_valid = accept && ((func == cbm_pkg::FUNC_CPU_READ) ||
                                (func == cbm_pkg::FUNC_VIDEO_READ));
        if (prg_re) begin
            n_src = cbm_pkg::SRC_PRG;
        end else if (pat_re) begin
            n_src = cbm_pkg::SRC_PAT;
        end else if (nt_re) begin
            n_src = cbm_pkg::SRC_NT;
        end else if (pal_re) begin
            n_src = cbm_pkg::SRC_PAL;
        end else begin
            n_src = cbm_pkg::SRC_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prg_we) begin
            prg_mem[prg_addr] <= i_write_data;
        end
        if (prg_re) begin
            r_prg_rdata <= prg_mem[prg_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[pat_addr] <= i_write_data;
        end
        if (pat_re) begin
            r_pat_rdata <= pat_mem[pat_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            nt_mem[nt_addr] <= i_write_data;
        end
        if (nt_re) begin
            r_nt_rdata <= nt_mem[nt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_addr] <= i_write_data;
        end
        if (pal_re) begin
            r_pal_rdata <= pal_mem[pal_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertical_mirroring <= 1'b0;
            r_two_prg_banks      <= 1'b1;
            r_rd_valid           <= 1'b0;
            r_src                <= cbm_pkg::SRC_ZERO;
        end else begin
            r_rd_valid <= n_rd_valid;
            r_src      <= n_src;
            if (i_cfg_we) begin
                case (cbm_pkg::t_cfg_index'(i_cfg_index))
                    cbm_pkg::CFG_VERTICAL_MIRRORING: r_vertical_mirroring <= i_cfg_wdata[0];
                    cbm_pkg::CFG_TWO_PRG_BANKS:      r_two_prg_banks      <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_read_valid = r_rd_valid;

    always_comb begin
        case (r_src)
            cbm_pkg::SRC_PRG: o_read_data = r_prg_rdata;
            cbm_pkg::SRC_PAT: o_read_data = r_pat_rdata;
            cbm_pkg::SRC_NT:  o_read_data = r_nt_rdata;
            cbm_pkg::SRC_PAL: o_read_data = r_pal_rdata;
            default:          o_read_data = '0;
        endcase
    end

    // A result beat appears in the cycle after a read is taken.
    a_read_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((func == cbm_pkg::FUNC_CPU_READ) ||
                    (func == cbm_pkg::FUNC_VIDEO_READ))) |=> o_read_valid)
        else $error("read access produced no result beat");

    a_write_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((func == cbm_pkg::FUNC_VIDEO_WRITE) ||
                    (func == cbm_pkg::FUNC_PRG_LOAD))) |=> !o_read_valid)
        else $error("write or load produced a result beat");

    a_one_read_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({prg_re, pat_re, nt_re, pal_re}))
        else $error("more than one memory read in a cycle");

    a_one_write_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({prg_we, pat_we, nt_we, pal_we}))
        else $error("more than one memory write in a cycle");

    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (func == cbm_pkg::FUNC_CPU_READ) && !i_bus_address[15])
        |=> (o_read_data == '0))
        else $error("unmapped CPU read returned nonzero data");

endmodule
